>>> hdl/line_clip_liang_barsky_assert.svh
// ----------------------------------------------------------------------------
// Line clipper assertion macros
// Property wrappers on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef LINE_CLIP_LIANG_BARSKY_ASSERT_SVH
`define LINE_CLIP_LIANG_BARSKY_ASSERT_SVH

`define LCLB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line clip check failed");

`define LCLB_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("line clip latency check failed");

`endif

>>> hdl/lclb_pkg.sv
// ----------------------------------------------------------------------------
// Line clipper package
// Widths, item types and register codes for the Liang-Barsky clipper.
// ----------------------------------------------------------------------------
package lclb_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int FRAC_BITS    = 16;

    localparam int CW           = COORD_WIDTH;
    localparam int DW           = CW + 1;          // differences
    localparam int RMW          = DW + 1;          // divider remainder
    localparam int QW           = FRAC_BITS + 1;   // quotient magnitude
    localparam int UW           = FRAC_BITS + 3;   // signed ratio / u values
    localparam int PW           = UW + DW;         // products
    localparam int VW           = PW + 1;          // rounding sum
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int PIPE_LATENCY = DIV_STEPS + 7;
    localparam int NUM_EDGES    = 4;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_LEFT,
        REG_WIN_TOP,
        REG_WIN_RIGHT,
        REG_WIN_BOTTOM
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
    } out_item_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [DW-1:0]  dvs;
        logic [QW-1:0]  quo;
        logic           neg;
        logic           pzero;
        logic           qneg;
        logic           pneg;
        logic           sat;
    } lane_t;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        in_item_t             orig;
    } geom_t;

    typedef struct packed {
        logic                 ok;
        logic signed [UW-1:0] u1;
        logic signed [UW-1:0] u2;
    } test_t;

endpackage

>>> hdl/line_clip_liang_barsky.sv
// ----------------------------------------------------------------------------
// Liang-Barsky line clipper
// Clips one segment per clock against the window held in four registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at any
//   edge with start high. busy is always low: the pipeline takes one item
//   every cycle.
//   Result channel: done is high for one cycle with result valid; the
//   receiver must take it then.
//   Latency: an item passes stage A, setup B, the DIV_STEPS divider stages,
//   then R, T1, T2, M and the output register. Throughput: one item per
//   cycle. The four parallel radix-2 dividers give one quotient bit a stage.
//   Config: cfg_we/cfg_index/cfg_data write a window register at once;
//   write only while no item is in flight.
//   Reset: clears all pipeline valids and sets the window to 0,0,639,479.
// ----------------------------------------------------------------------------
module line_clip_liang_barsky (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lclb_pkg::in_item_t                  in_item,
    output logic                                done,
    output lclb_pkg::out_item_t                 result,
    input  logic                                cfg_we,
    input  logic [lclb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lclb_pkg::COORD_WIDTH-1:0]    cfg_data
);
    import lclb_pkg::*;

    localparam logic signed [UW-1:0] U_ONE   = UW'(2**FRAC_BITS);
    localparam logic signed [UW-1:0] SAT_MAG = UW'(2**(FRAC_BITS+1));
    localparam logic signed [VW-1:0] HALF    = VW'(2**(FRAC_BITS-1));

    typedef struct packed {
        lane_t [NUM_EDGES-1:0] lane;
        geom_t                 geom;
    } divst_t;

    // window registers
    logic signed [CW-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= CW'(0);
            win_top_reg    <= CW'(0);
            win_right_reg  <= CW'(639);
            win_bottom_reg <= CW'(479);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_TOP:    win_top_reg    <= cfg_data;
                REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage A: edge terms
    logic signed [DW-1:0] a_p_next [NUM_EDGES];
    logic signed [DW-1:0] a_q_next [NUM_EDGES];
    logic signed [DW-1:0] a_p_reg  [NUM_EDGES];
    logic signed [DW-1:0] a_q_reg  [NUM_EDGES];
    geom_t                a_geom_next, a_geom_reg;
    logic                 a_valid_reg;

    always_comb
    begin
        a_geom_next.orig = in_item;
        a_geom_next.dx   = DW'(in_item.end_x) - DW'(in_item.start_x);
        a_geom_next.dy   = DW'(in_item.end_y) - DW'(in_item.start_y);
        a_p_next[0] = -a_geom_next.dx;
        a_q_next[0] = DW'(in_item.start_x) - DW'(win_left_reg);
        a_p_next[1] = a_geom_next.dx;
        a_q_next[1] = DW'(win_right_reg) - DW'(in_item.start_x);
        a_p_next[2] = -a_geom_next.dy;
        a_q_next[2] = DW'(in_item.start_y) - DW'(win_top_reg);
        a_p_next[3] = a_geom_next.dy;
        a_q_next[3] = DW'(win_bottom_reg) - DW'(in_item.start_y);
    end

    always_ff @(posedge clk)
    begin
        a_p_reg    <= a_p_next;
        a_q_reg    <= a_q_next;
        a_geom_reg <= a_geom_next;
    end

    // ---------------- stage B: divider setup
    divst_t div_reg   [DIV_STEPS+1];
    logic   div_valid_reg [DIV_STEPS+1];
    divst_t b_next;

    always_comb
    begin
        b_next.geom = a_geom_reg;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            logic [DW-1:0] pm;
            logic [DW-1:0] qm;
            pm = a_p_reg[i][DW-1] ? DW'(-a_p_reg[i]) : DW'(a_p_reg[i]);
            qm = a_q_reg[i][DW-1] ? DW'(-a_q_reg[i]) : DW'(a_q_reg[i]);
            b_next.lane[i].pneg  = a_p_reg[i][DW-1];
            b_next.lane[i].qneg  = a_q_reg[i][DW-1];
            b_next.lane[i].pzero = (a_p_reg[i] == '0);
            b_next.lane[i].neg   = a_p_reg[i][DW-1] ^ a_q_reg[i][DW-1];
            b_next.lane[i].sat   = ({1'b0, qm} >= {pm, 1'b0});
            b_next.lane[i].rem   = {1'b0, qm};
            b_next.lane[i].dvs   = pm;
            b_next.lane[i].quo   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0] <= b_next;
    end

    // ---------------- divider: one quotient bit per stage
    function automatic lane_t div_step(lane_t l, logic first);
        lane_t         o;
        logic [RMW-1:0] sh;
        o  = l;
        sh = first ? l.rem : {l.rem[RMW-2:0], 1'b0};
        if (sh >= {1'b0, l.dvs})
        begin
            o.rem = sh - {1'b0, l.dvs};
            o.quo = {l.quo[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh;
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        divst_t step_next;
        always_comb
        begin
            step_next.geom = div_reg[k].geom;
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                step_next.lane[i] = div_step(div_reg[k].lane[i], (k == 0));
            end
        end
        always_ff @(posedge clk)
        begin
            div_reg[k+1] <= step_next;
        end
    end

    // ---------------- stage R: signed, saturated ratio
    logic signed [UW-1:0] r_next [NUM_EDGES];
    logic signed [UW-1:0] r_reg  [NUM_EDGES];
    lane_t                r_lane_reg [NUM_EDGES];
    geom_t                r_geom_reg;
    logic                 r_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            logic signed [UW-1:0] mag;
            mag = div_reg[DIV_STEPS].lane[i].sat ? SAT_MAG
                                                 : UW'(div_reg[DIV_STEPS].lane[i].quo);
            r_next[i] = div_reg[DIV_STEPS].lane[i].neg ? -mag : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        r_geom_reg <= div_reg[DIV_STEPS].geom;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            r_lane_reg[i] <= div_reg[DIV_STEPS].lane[i];
        end
    end

    // ---------------- stages T1, T2: edge tests
    function automatic test_t edge_step(test_t t, logic signed [UW-1:0] r, lane_t l);
        test_t o;
        o = t;
        if (t.ok)
        begin
            if (l.pzero)
            begin
                if (l.qneg)
                    o.ok = 1'b0;
            end
            else if (l.pneg)
            begin
                if (r > t.u2)
                    o.ok = 1'b0;
                else if (r > t.u1)
                    o.u1 = r;
            end
            else
            begin
                if (r < t.u1)
                    o.ok = 1'b0;
                else if (r < t.u2)
                    o.u2 = r;
            end
        end
        return o;
    endfunction

    test_t                t1_next, t1_reg, t2_next, t2_reg;
    logic signed [UW-1:0] t1_r_reg [2];
    lane_t                t1_lane_reg [2];
    geom_t                t1_geom_reg, t2_geom_reg;
    logic                 t1_valid_reg, t2_valid_reg;

    always_comb
    begin
        test_t t0;
        t0.ok   = 1'b1;
        t0.u1   = '0;
        t0.u2   = U_ONE;
        t1_next = edge_step(edge_step(t0, r_reg[0], r_lane_reg[0]), r_reg[1], r_lane_reg[1]);
        t2_next = edge_step(edge_step(t1_reg, t1_r_reg[0], t1_lane_reg[0]),
                            t1_r_reg[1], t1_lane_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        t1_reg         <= t1_next;
        t1_r_reg[0]    <= r_reg[2];
        t1_r_reg[1]    <= r_reg[3];
        t1_lane_reg[0] <= r_lane_reg[2];
        t1_lane_reg[1] <= r_lane_reg[3];
        t1_geom_reg    <= r_geom_reg;
        t2_reg         <= t2_next;
        t2_geom_reg    <= t1_geom_reg;
    end

    // ---------------- stage M: products
    logic signed [PW-1:0] m_sx_next, m_sy_next, m_ex_next, m_ey_next;
    logic signed [PW-1:0] m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    logic                 m_ok_reg, m_mvs_reg, m_mve_reg;
    in_item_t             m_orig_reg;
    logic                 m_valid_reg;

    always_comb
    begin
        m_sx_next = t2_reg.u1 * t2_geom_reg.dx;
        m_sy_next = t2_reg.u1 * t2_geom_reg.dy;
        m_ex_next = t2_reg.u2 * t2_geom_reg.dx;
        m_ey_next = t2_reg.u2 * t2_geom_reg.dy;
    end

    always_ff @(posedge clk)
    begin
        m_sx_reg   <= m_sx_next;
        m_sy_reg   <= m_sy_next;
        m_ex_reg   <= m_ex_next;
        m_ey_reg   <= m_ey_next;
        m_ok_reg   <= t2_reg.ok;
        m_mvs_reg  <= (t2_reg.u1 > '0);
        m_mve_reg  <= (t2_reg.u2 < U_ONE);
        m_orig_reg <= t2_geom_reg.orig;
    end

    // ---------------- stage F: round and select
    function automatic logic signed [CW-1:0] round_pt(logic signed [CW-1:0] base,
                                                      logic signed [PW-1:0] prod);
        logic signed [VW-1:0] v;
        v = (VW'(base) <<< FRAC_BITS) + VW'(prod) + HALF;
        return v[FRAC_BITS +: CW];
    endfunction

    out_item_t result_next, result_reg;
    logic      done_reg;

    always_comb
    begin
        result_next.visible      = m_ok_reg;
        result_next.clip_start_x = m_orig_reg.start_x;
        result_next.clip_start_y = m_orig_reg.start_y;
        result_next.clip_end_x   = m_orig_reg.end_x;
        result_next.clip_end_y   = m_orig_reg.end_y;
        if (m_ok_reg && m_mve_reg)
        begin
            result_next.clip_end_x = round_pt(m_orig_reg.start_x, m_ex_reg);
            result_next.clip_end_y = round_pt(m_orig_reg.start_y, m_ey_reg);
        end
        if (m_ok_reg && m_mvs_reg)
        begin
            result_next.clip_start_x = round_pt(m_orig_reg.start_x, m_sx_reg);
            result_next.clip_start_y = round_pt(m_orig_reg.start_y, m_sy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            div_valid_reg <= '{default: 1'b0};
            r_valid_reg   <= 1'b0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg      <= start && !busy;
            div_valid_reg[0] <= a_valid_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
            r_valid_reg  <= div_valid_reg[DIV_STEPS];
            t1_valid_reg <= r_valid_reg;
            t2_valid_reg <= t1_valid_reg;
            m_valid_reg  <= t2_valid_reg;
            done_reg     <= m_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/lclb_checker.sv
// ----------------------------------------------------------------------------
// Line clipper port checker
// Latency and pass-through checks on the clipper ports.
// ----------------------------------------------------------------------------
`include "line_clip_liang_barsky_assert.svh"

module lclb_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  lclb_pkg::in_item_t     in_item,
    input  logic                   done,
    input  lclb_pkg::out_item_t    result
);
    import lclb_pkg::*;

    logic                 rejected;
    logic [4*CW-1:0]      res_pts;

    // result coordinates share the field order of the input item
    assign rejected = done && !result.visible;
    assign res_pts  = result[4*CW-1:0];

    `LCLB_ASSERT_DELAY(a_item_gives_result, start && !busy, PIPE_LATENCY, done)
    `LCLB_ASSERT_IMPL(a_result_has_item, done, $past(start && !busy, PIPE_LATENCY))
    `LCLB_ASSERT_IMPL(a_reject_passes, rejected, res_pts == $past(in_item, PIPE_LATENCY))

endmodule

bind line_clip_liang_barsky lclb_checker u_lclb_checker (.*);
